@@ src/ltd_pkg.sv @@
// Package for the LRU tag directory: request and result payload types,
// action and status codes, controller state and control structs.
// No dependencies.
package ltd_pkg;

  localparam int DEF_NUM_SLOTS  = 4;
  localparam int DEF_KEY_BITS   = 16;
  localparam int DEF_STAMP_BITS = 64;

  localparam int SONG_KEY_BITS = 16;
  localparam int SLOT_OUT_BITS = 2;

  typedef enum logic [1:0] {
    ACT_PRIME = 2'd0,
    ACT_GET   = 2'd1,
    ACT_CLEAR = 2'd2
  } ltd_action_e;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_HIT      = 3'd1,
    ST_FILLED   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_CLEARED  = 3'd4
  } ltd_status_e;

  typedef struct packed {
    logic [1:0]                      action;
    logic signed [SONG_KEY_BITS-1:0] song_key;
    logic                            content_ok;
    logic                            want_big;
  } ltd_req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [SLOT_OUT_BITS-1:0] slot_index;
    logic                     content_present;
    logic                     big_selected;
  } ltd_result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_COMMIT
  } ltd_state_e;

  typedef struct packed {
    logic load;
    logic lookup;
    logic scan_step;
    logic commit;
  } ltd_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } ltd_stat_t;

endpackage

@@ src/ltd_ctrl.sv @@
// Controller of the LRU tag directory: sequences lookup, victim scan and commit.
// Depends on ltd_pkg.
module ltd_ctrl import ltd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  ltd_stat_t stat_i,
  output ltd_cmd_t  cmd_o,
  output logic      busy
);

  ltd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = stat_i.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ src/ltd_datapath.sv @@
// Datapath of the LRU tag directory: slot tags, flags, stamps, use counter,
// parallel tag compare, serial victim scan and result register.
// Depends on ltd_pkg.
module ltd_datapath import ltd_pkg::*; #(
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ltd_cmd_t    cmd_i,
  input  ltd_req_t    req_i,
  output ltd_stat_t   stat_o,
  output logic        result_valid_o,
  output ltd_result_t result_o
);

  localparam int IdxBits = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [KEY_BITS-1:0]   key_q   [NUM_SLOTS];
  logic [STAMP_BITS-1:0] stamp_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  empty_q;
  logic [NUM_SLOTS-1:0]  content_q;
  logic [STAMP_BITS-1:0] counter_q;

  ltd_req_t              req_q;
  logic [KEY_BITS-1:0]   req_key;
  logic                  negative;
  logic                  hit_q;
  logic [IdxBits-1:0]    hit_idx_q;
  logic                  hit_any;
  logic [IdxBits-1:0]    hit_idx;
  logic [IdxBits-1:0]    scan_idx_q;
  logic [IdxBits-1:0]    vic_q;
  logic [STAMP_BITS-1:0] best_stamp_q;
  logic [STAMP_BITS-1:0] next_stamp;

  logic        do_clear, do_touch, do_fill;
  ltd_result_t res_d, res_q;
  logic        valid_q;

  if (KEY_BITS <= SONG_KEY_BITS) begin : g_key_trunc
    assign req_key = req_q.song_key[KEY_BITS-1:0];
  end else begin : g_key_ext
    assign req_key = {{(KEY_BITS-SONG_KEY_BITS){1'b0}}, req_q.song_key};
  end

  assign negative   = req_q.song_key[SONG_KEY_BITS-1];
  assign next_stamp = counter_q + STAMP_BITS'(1);

  // tag compare, lowest matching slot wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!empty_q[i] && key_q[i] == req_key) begin
        hit_any = 1'b1;
        hit_idx = IdxBits'(i);
      end
    end
  end

  assign stat_o.need_scan = (req_q.action == ACT_PRIME) && !negative && !hit_any;
  assign stat_o.scan_done = empty_q[scan_idx_q] ||
                            (scan_idx_q == IdxBits'(NUM_SLOTS - 1));

  always_comb begin
    res_d    = '0;
    do_clear = 1'b0;
    do_touch = 1'b0;
    do_fill  = 1'b0;
    res_d.status = ST_IGNORED;
    unique case (req_q.action)
      ACT_CLEAR: begin
        do_clear     = 1'b1;
        res_d.status = ST_CLEARED;
      end
      ACT_PRIME: begin
        if (!negative) begin
          if (hit_q) begin
            do_touch              = 1'b1;
            res_d.status          = ST_HIT;
            res_d.slot_index      = SLOT_OUT_BITS'(hit_idx_q);
            res_d.content_present = content_q[hit_idx_q];
          end else begin
            do_fill               = 1'b1;
            res_d.status          = ST_FILLED;
            res_d.slot_index      = SLOT_OUT_BITS'(vic_q);
            res_d.content_present = req_q.content_ok;
          end
        end
      end
      ACT_GET: begin
        if (!negative) begin
          if (hit_q && content_q[hit_idx_q]) begin
            do_touch              = 1'b1;
            res_d.status          = ST_HIT;
            res_d.slot_index      = SLOT_OUT_BITS'(hit_idx_q);
            res_d.content_present = 1'b1;
            res_d.big_selected    = req_q.want_big;
          end else begin
            res_d.status = ST_NOTFOUND;
          end
        end
      end
      default: begin
        res_d.status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q   <= '1;
      content_q <= '0;
      counter_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (do_clear) begin
          empty_q   <= '1;
          content_q <= '0;
          counter_q <= '0;
        end
        if (do_touch || do_fill) begin
          counter_q <= next_stamp;
        end
        if (do_fill) begin
          empty_q[vic_q]   <= 1'b0;
          content_q[vic_q] <= req_q.content_ok;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.lookup) begin
      hit_q      <= hit_any;
      hit_idx_q  <= hit_idx;
      scan_idx_q <= '0;
    end
    // victim scan: first empty slot, else oldest stamp, lowest index on ties
    if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + IdxBits'(1);
      if (empty_q[scan_idx_q]) begin
        vic_q <= scan_idx_q;
      end else if (scan_idx_q == '0 || stamp_q[scan_idx_q] < best_stamp_q) begin
        vic_q        <= scan_idx_q;
        best_stamp_q <= stamp_q[scan_idx_q];
      end
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
      if (do_touch) begin
        stamp_q[hit_idx_q] <= next_stamp;
      end
      if (do_fill) begin
        stamp_q[vic_q] <= next_stamp;
        key_q[vic_q]   <= req_key;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

@@ src/lru_tag_directory.sv @@
// Top level of the LRU tag directory: controller plus datapath.
// Depends on ltd_pkg, ltd_ctrl and ltd_datapath.
//
// A request is taken when start is high while busy is low. Its result shows
// on result_o for one cycle with result_valid_o high, and cannot be held
// off. Every request keeps busy high through the lookup and commit states
// after acceptance and its result shows in the cycle after commit, so a
// request is not taken before the previous one is through; a prime that
// misses adds a victim scan of one slot per cycle, stopping at the first
// empty or last slot. The scan shares a single stamp comparator across slots.
// A new request may be taken in the cycle its predecessor's result is shown.
module lru_tag_directory import ltd_pkg::*; #(
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ltd_req_t    req_i,
  output logic        result_valid_o,
  output ltd_result_t result_o
);

  ltd_cmd_t  cmd;
  ltd_stat_t stat;

  ltd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  ltd_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_i          (req_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ sim/ltd_checker.sv @@
// Checker for the LRU tag directory: watches the request and result channels,
// predicts each result from its own copy of the slot state and compares fields.
// Depends on ltd_pkg.
`timescale 1ns / 1ps

module ltd_checker import ltd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  ltd_req_t    req_i,
  input  logic        result_valid_i,
  input  ltd_result_t result_i,
  output int          outstanding_o,
  output int          mismatches_o,
  output int          checked_o
);

  localparam int NUM_SLOTS  = DEF_NUM_SLOTS;
  localparam int KEY_W      = DEF_KEY_BITS;
  localparam int STAMP_W    = DEF_STAMP_BITS;

  logic [KEY_W-1:0]   slot_key   [NUM_SLOTS];
  logic               slot_empty [NUM_SLOTS];
  logic               slot_full  [NUM_SLOTS];
  logic [STAMP_W-1:0] slot_stamp [NUM_SLOTS];
  logic [STAMP_W-1:0] use_count;

  ltd_result_t awaited_results[$];
  ltd_result_t want;

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches_o++;
  endtask

  function automatic logic [STAMP_W-1:0] fresh_stamp();
    use_count = use_count + 1'b1;
    return use_count;
  endfunction

  // Applies one request to the slot state and returns the result it yields.
  function automatic ltd_result_t apply_request(ltd_req_t r);
    ltd_result_t      res;
    logic [KEY_W-1:0] key;
    logic             neg;
    int               hit;
    int               victim;
    int               oldest;
    res = '0;
    res.status = ST_IGNORED;
    key = r.song_key[KEY_W-1:0];
    neg = r.song_key[SONG_KEY_BITS-1];
    hit = -1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (hit < 0 && !slot_empty[i] && slot_key[i] == key) hit = i;
    case (r.action)
      ACT_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          slot_empty[i] = 1'b1;
          slot_full[i]  = 1'b0;
        end
        use_count  = '0;
        res.status = ST_CLEARED;
      end
      ACT_PRIME: begin
        if (!neg) begin
          if (hit >= 0) begin
            slot_stamp[hit]     = fresh_stamp();
            res.status          = ST_HIT;
            res.slot_index      = hit[SLOT_OUT_BITS-1:0];
            res.content_present = slot_full[hit];
          end else begin
            victim = -1;
            oldest = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (victim < 0 && slot_empty[i]) victim = i;
              if (slot_stamp[i] < slot_stamp[oldest]) oldest = i;
            end
            if (victim < 0) victim = oldest;
            slot_key[victim]    = key;
            slot_empty[victim]  = 1'b0;
            slot_stamp[victim]  = fresh_stamp();
            slot_full[victim]   = r.content_ok;
            res.status          = ST_FILLED;
            res.slot_index      = victim[SLOT_OUT_BITS-1:0];
            res.content_present = r.content_ok;
          end
        end
      end
      ACT_GET: begin
        if (!neg) begin
          if (hit >= 0 && slot_full[hit]) begin
            slot_stamp[hit]     = fresh_stamp();
            res.status          = ST_HIT;
            res.slot_index      = hit[SLOT_OUT_BITS-1:0];
            res.content_present = 1'b1;
            res.big_selected    = r.want_big;
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
      end
      default: res.status = ST_IGNORED;
    endcase
    return res;
  endfunction

  initial begin
    mismatches_o = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_key[i]   = '0;
        slot_empty[i] = 1'b1;
        slot_full[i]  = 1'b0;
        slot_stamp[i] = '0;
      end
      use_count = '0;
      awaited_results.delete();
      outstanding_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request pending", result_i.status, -1);
        end else begin
          want = awaited_results.pop_front();
          checked_o++;
          if (result_i.status !== want.status)
            report_mismatch("status", result_i.status, want.status);
          if (result_i.slot_index !== want.slot_index)
            report_mismatch("slot_index", result_i.slot_index, want.slot_index);
          if (result_i.content_present !== want.content_present)
            report_mismatch("content_present", result_i.content_present,
                            want.content_present);
          if (result_i.big_selected !== want.big_selected)
            report_mismatch("big_selected", result_i.big_selected, want.big_selected);
        end
      end
      if (start_i && !busy_i) awaited_results.push_back(apply_request(req_i));
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

@@ sim/lru_tag_directory_tb.sv @@
// Testbench top for the LRU tag directory: clock, reset, request stimulus and
// verdict. Depends on ltd_pkg, lru_tag_directory and ltd_checker.
`timescale 1ns / 1ps

module lru_tag_directory_tb import ltd_pkg::*; ();

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int CALM_TAIL      = 300;
  localparam int DRAIN_EVERY    = 450;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REQ_W          = $bits(ltd_req_t);

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  ltd_req_t    req_i;
  logic        result_valid_o;
  ltd_result_t result_o;

  int outstanding;
  int mismatches;
  int checked;
  int quiet_cycles;
  int n_prime, n_get, n_clear, n_other;

  lru_tag_directory u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  ltd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .result_valid_i(result_valid_o),
    .result_i      (result_o),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches),
    .checked_o     (checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Request is held until taken on an edge where busy is low.
  task automatic issue(logic [1:0] act, logic [15:0] key, logic ok, logic big);
    req_i <= '{action: act, song_key: key, content_ok: ok, want_big: big};
    start <= 1'b1;
    case (act)
      ACT_PRIME: n_prime++;
      ACT_GET:   n_get++;
      ACT_CLEAR: n_clear++;
      default:   n_other++;
    endcase
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    req_i <= ltd_req_t'(REQ_W'($urandom));
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly a small key pool so slots hit and get evicted.
  function automatic logic [15:0] pick_key();
    logic [15:0] k;
    case ($urandom_range(0, 9))
      0:       k = 16'($urandom_range(0, 32767));
      1:       k = 16'($urandom_range(32768, 65535));
      2:       k = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      default: k = 16'($urandom_range(0, 5));
    endcase
    return k;
  endfunction

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0] act;
    int         pick;
    start        = 1'b0;
    req_i        = '0;
    rst_ni       = 1'b0;
    quiet_cycles = 0;
    n_prime = 0; n_get = 0; n_clear = 0; n_other = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(ACT_PRIME, 16'd0, 1'b1, 1'b0);
    issue(ACT_PRIME, 16'd0, 1'b0, 1'b0);
    issue(ACT_GET, 16'd0, 1'b0, 1'b1);
    issue(ACT_GET, 16'd0, 1'b1, 1'b0);
    issue(ACT_PRIME, 16'h7fff, 1'b0, 1'b1);
    issue(ACT_GET, 16'h7fff, 1'b1, 1'b1);
    issue(ACT_GET, 16'd7, 1'b1, 1'b1);
    issue(ACT_PRIME, 16'h8000, 1'b1, 1'b1);
    issue(ACT_GET, 16'hffff, 1'b1, 1'b1);
    issue(ACT_PRIME, 16'd1, 1'b1, 1'b0);
    issue(ACT_PRIME, 16'd2, 1'b1, 1'b0);
    issue(ACT_PRIME, 16'd3, 1'b1, 1'b0);
    issue(ACT_GET, 16'd3, 1'b0, 1'b1);
    issue(ACT_PRIME, 16'h7fff, 1'b1, 1'b0);
    issue(ACT_RESERVED, 16'd5, 1'b1, 1'b1);
    issue(ACT_CLEAR, 16'hffff, 1'b1, 1'b1);
    issue(ACT_GET, 16'd0, 1'b0, 1'b0);
    issue(ACT_PRIME, 16'd2, 1'b1, 1'b0);
    issue(ACT_PRIME, 16'h5555, 1'b0, 1'b0);
    issue(ACT_PRIME, 16'h2aaa, 1'b1, 1'b0);
    issue(ACT_PRIME, 16'd6, 1'b1, 1'b0);
    issue(ACT_PRIME, 16'd7, 1'b1, 1'b1);
    issue(ACT_GET, 16'h5555, 1'b1, 1'b1);
    issue(ACT_GET, 16'h2aaa, 1'b0, 1'b1);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 46)      act = ACT_PRIME;
      else if (pick < 92) act = ACT_GET;
      else if (pick < 97) act = ACT_CLEAR;
      else                act = ACT_RESERVED;
      issue(act, pick_key(), $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
      else if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 9));
    end
    drain();

    $display("Covered %0d requests: %0d prime, %0d get, %0d clear, %0d unused action.",
             n_prime + n_get + n_clear + n_other, n_prime, n_get, n_clear, n_other);
    $display("%0d results checked field by field, %0d mismatches.", checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
